// ----- rtl/domix_pkg.sv -----
package domix_pkg;

	// shared multiplier: 18x18 signed, full product
	localparam int MUL_W  = 18;
	localparam int PROD_W = 2 * MUL_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 48;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CONF   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONF_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHAS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAG_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAG_SCALE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_BND  = 3'd6;

	// register reset values
	localparam logic [15:0] RST_MIN_CONF   = 16'd19661;
	localparam logic [15:0] RST_CONF_SCALE = 16'd366;
	localparam logic [15:0] RST_MASTER     = 16'd32768;
	localparam logic [47:0] RST_ALPHAS     = 48'h4000_4000_4000;
	localparam logic [15:0] RST_MAG_LOW    = 16'd0;
	localparam logic [15:0] RST_MAG_SCALE  = 16'd256;
	localparam logic [31:0] RST_PITCH_BND  = 32'h8000_2000;

	// fixed-point constants
	localparam logic [15:0] GAIN_FULL   = 16'd32768; // 1.0 in Q1.15
	localparam logic [15:0] RAW_MIN     = 16'd3;     // gains at or below are skipped
	localparam logic [15:0] GATE_MIN    = 16'd328;   // pitch gate, about 0.01
	localparam logic [15:0] PITCH_UNITY = 16'd16384; // 1.0 in Q2.14
	localparam logic [16:0] HEIGHT_MID  = 17'd16384; // 0.5 in Q1.15
	localparam logic [16:0] RATIO_FULL  = 17'h10000; // 1.0 in Q1.16

endpackage

// ----- rtl/domix_mul.sv -----
module domix_mul (
	input  logic                                clk,
	input  logic signed [domix_pkg::MUL_W-1:0]  a,
	input  logic signed [domix_pkg::MUL_W-1:0]  b,
	output logic signed [domix_pkg::PROD_W-1:0] p_q
);
	import domix_pkg::*;

	// registered product, one multiply per cycle
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ----- rtl/dominant_obstacle_audio_mixer.sv -----
// Dominant-obstacle audio mixer.
//
// Input channel (in_valid/in_ready): one tracked obstacle per transaction.
// Obstacles of one frame arrive in order; frame_last marks the final one.
// Output channel (out_valid/out_ready): after a frame_last item the block
// emits NUM_SOURCES results, source 0 first, result_last on the last one.
// Config channel (cfg_valid/cfg_index/cfg_data): always ready, write only
// while no item or result is in flight.
//
// Datapath: all multiplies go through one registered 18x18 multiplier under
// a small sequencer. An active obstacle runs the confidence, suppression,
// master and weight steps before in_ready returns; an inactive non-last one
// leaves in_ready high. At frame end each side source smooths gain, height
// and, gate open, pitch; a muted one gain only; a full output register stalls.
// in_ready is low while the sequencer runs. A finished result waits in the
// output register; if the receiver stalls, the sequencer holds before the
// next result, and the next obstacle can be accepted while the frame's last
// result is still waiting.
// Reset: registers return to their defaults, smoothed gains and heights go
// to zero, smoothed pitch to 1.0, no result pending.
module dominant_obstacle_audio_mixer #(
	parameter int NUM_SOURCES = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [domix_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [domix_pkg::CFG_DAT_W-1:0]       cfg_data,
	// obstacles in
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  obstacle_active,
	input  logic [15:0]                           obstacle_confidence,
	input  logic [15:0]                           norm_x,
	input  logic [15:0]                           norm_y,
	input  logic [15:0]                           obstacle_magnitude,
	input  logic [15:0]                           suppression,
	input  logic                                  frame_last,
	// results out
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            source_index,
	output logic [15:0]                           source_gain,
	output logic signed [16:0]                    source_height,
	output logic [15:0]                           source_pitch,
	output logic                                  pitch_valid,
	output logic                                  result_last
);
	import domix_pkg::*;

	localparam int SIDX_W = $clog2(NUM_SOURCES);
	localparam int EMA_W  = 20;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CN,    // start confidence product
		ST_RS,    // normalize, times suppression
		ST_RM,    // times master gain
		ST_WL,    // raw gain ready, left weight
		ST_WR,    // left update, right weight
		ST_WU,    // right update
		ST_G,     // gain smoothing product
		ST_GU,    // gain update, height product
		ST_HU,    // height update, pitch ratio product
		ST_P1,    // ratio ready, interpolate
		ST_P2,    // target ready, pitch smoothing product
		ST_P3,    // pitch update
		ST_EMIT   // load output register
	} state_t;

	state_t state_q;

	// config registers
	logic [15:0] min_conf_q, conf_scale_q, master_q, mag_low_q, mag_scale_q;
	logic [47:0] alphas_q;
	logic [31:0] pitch_bnd_q;

	// captured obstacle
	logic        last_q;
	logic [15:0] conf_q, nx_q, ny_q, mag_q, supp_q;
	logic [15:0] raw_q;

	// per-frame best and smoothed state
	logic [15:0]        bg_q [2];
	logic signed [16:0] bh_q [2];
	logic [15:0]        bm_q [2];
	logic signed [16:0] sh_q [2];
	logic [15:0]        sp_q [2];
	logic [15:0]        sg_q [NUM_SOURCES];

	logic [SIDX_W-1:0]  src_q;
	logic               pv_q;

	// output register
	logic               out_valid_q;
	logic [1:0]         oidx_q;
	logic [15:0]        ogain_q, opitch_q;
	logic signed [16:0] ohgt_q;
	logic               opv_q, olast_q;
	logic               emit_go;

	// multiplier
	logic signed [MUL_W-1:0]  a_op, b_op;
	logic signed [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0]        prod_u;

	domix_mul u_mul (
		.clk (clk),
		.a   (a_op),
		.b   (b_op),
		.p_q (prod_q)
	);

	function automatic logic [15:0] sat15(input logic [PROD_W-1:0] v);
		sat15 = (v > PROD_W'(GAIN_FULL)) ? GAIN_FULL : v[15:0];
	endfunction

	function automatic logic signed [EMA_W-1:0] ema_add(
		input logic signed [EMA_W-1:0]  old,
		input logic signed [PROD_W-1:0] p
	);
		ema_add = old + EMA_W'(p >>> 16);
	endfunction

	// field selects
	logic [15:0] alpha_g, alpha_h, alpha_p, plo, phi;
	assign alpha_g = alphas_q[15:0];
	assign alpha_h = alphas_q[31:16];
	assign alpha_p = alphas_q[47:32];
	assign plo     = pitch_bnd_q[15:0];
	assign phi     = pitch_bnd_q[31:16];

	// current source view
	logic [SIDX_W+1:0]   src_ext;
	logic                is_side, side, src_last;
	logic [15:0]         sg_cur, bg_cur, bm_cur, sp_cur, raw_now, wgt;
	logic signed [16:0]  sh_cur, bh_cur, hgt_new;
	logic [16:0]         wl_op, ratio;
	logic [15:0]         mdiff;
	logic                conf_above;

	assign prod_u   = prod_q;
	assign src_ext  = {2'b00, src_q};
	assign is_side  = (src_ext < (SIDX_W+2)'(2));
	assign side     = src_q[0];
	assign src_last = (src_q == SIDX_W'(NUM_SOURCES - 1));
	assign sg_cur   = sg_q[src_q];
	assign bg_cur   = bg_q[side];
	assign bm_cur   = bm_q[side];
	assign sp_cur   = sp_q[side];
	assign sh_cur   = sh_q[side];
	assign bh_cur   = bh_q[side];

	assign conf_above = (conf_q > min_conf_q);
	assign raw_now    = sat15(prod_u >> 15);
	assign wgt        = prod_u[31:16];
	assign wl_op      = RATIO_FULL - {1'b0, nx_q};
	assign hgt_new    = $signed(HEIGHT_MID) - $signed({2'b00, ny_q[15:1]});
	assign mdiff      = (bm_cur > mag_low_q) ? (bm_cur - mag_low_q) : 16'd0;
	assign ratio      = (prod_u > PROD_W'(RATIO_FULL)) ? RATIO_FULL : prod_u[16:0];

	// output register takes a new result when empty or draining this cycle
	assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// smoothing and pitch interpolation
	logic signed [MUL_W-1:0]  diff_g, diff_h, diff_pb, diff_p;
	logic signed [PROD_W-1:0] p_adj;
	logic signed [EMA_W-1:0]  g_new, h_new, p_new, tp;

	assign diff_g  = $signed(MUL_W'(is_side ? bg_cur : 16'd0)) - $signed(MUL_W'(sg_cur));
	assign diff_h  = MUL_W'(bh_cur) - MUL_W'(sh_cur);
	assign diff_pb = $signed(MUL_W'(phi)) - $signed(MUL_W'(plo));
	// quotient truncates toward zero
	assign p_adj   = prod_q[PROD_W-1] ? (prod_q + $signed(PROD_W'(16'hFFFF))) : prod_q;
	assign tp      = $signed(EMA_W'(plo)) + EMA_W'(p_adj >>> 16);
	assign diff_p  = MUL_W'(tp - $signed(EMA_W'(sp_cur)));
	assign g_new   = ema_add($signed(EMA_W'(sg_cur)), prod_q);
	assign h_new   = ema_add(EMA_W'(sh_cur), prod_q);
	assign p_new   = ema_add($signed(EMA_W'(sp_cur)), prod_q);

	// operand select for the shared multiplier
	always_comb begin
		a_op = '0;
		b_op = '0;
		case (state_q)
			ST_CN: begin
				a_op = MUL_W'(conf_above ? (conf_q - min_conf_q) : 16'd0);
				b_op = MUL_W'(conf_scale_q);
			end
			ST_RS: begin
				a_op = MUL_W'(sat15(prod_u >> 9));
				b_op = MUL_W'(supp_q);
			end
			ST_RM: begin
				a_op = MUL_W'(sat15(prod_u >> 15));
				b_op = MUL_W'(master_q);
			end
			ST_WL: begin
				a_op = MUL_W'(wl_op);
				b_op = MUL_W'(raw_now);
			end
			ST_WR: begin
				a_op = MUL_W'(nx_q);
				b_op = MUL_W'(raw_q);
			end
			ST_G: begin
				a_op = MUL_W'(alpha_g);
				b_op = diff_g;
			end
			ST_GU: begin
				a_op = MUL_W'(alpha_h);
				b_op = diff_h;
			end
			ST_HU: begin
				a_op = MUL_W'(mdiff);
				b_op = MUL_W'(mag_scale_q);
			end
			ST_P1: begin
				a_op = MUL_W'(ratio);
				b_op = diff_pb;
			end
			ST_P2: begin
				a_op = MUL_W'(alpha_p);
				b_op = diff_p;
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			min_conf_q   <= RST_MIN_CONF;
			conf_scale_q <= RST_CONF_SCALE;
			master_q     <= RST_MASTER;
			alphas_q     <= RST_ALPHAS;
			mag_low_q    <= RST_MAG_LOW;
			mag_scale_q  <= RST_MAG_SCALE;
			pitch_bnd_q  <= RST_PITCH_BND;
			for (int i = 0; i < 2; i++) begin
				bg_q[i] <= '0;
				bh_q[i] <= '0;
				bm_q[i] <= '0;
				sh_q[i] <= '0;
				sp_q[i] <= PITCH_UNITY;
			end
			for (int i = 0; i < NUM_SOURCES; i++) begin
				sg_q[i] <= '0;
			end
			src_q       <= '0;
			pv_q        <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_CONF:   min_conf_q   <= cfg_data[15:0];
					REG_CONF_SCALE: conf_scale_q <= cfg_data[15:0];
					REG_MASTER:     master_q     <= cfg_data[15:0];
					REG_ALPHAS:     alphas_q     <= cfg_data[47:0];
					REG_MAG_LOW:    mag_low_q    <= cfg_data[15:0];
					REG_MAG_SCALE:  mag_scale_q  <= cfg_data[15:0];
					REG_PITCH_BND:  pitch_bnd_q  <= cfg_data[31:0];
					default: ;
				endcase
			end

			if (out_valid_q && out_ready && !emit_go) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q <= frame_last;
						conf_q <= obstacle_confidence;
						nx_q   <= norm_x;
						ny_q   <= norm_y;
						mag_q  <= obstacle_magnitude;
						supp_q <= suppression;
						src_q  <= '0;
						if (obstacle_active) begin
							state_q <= ST_CN;
						end else if (frame_last) begin
							state_q <= ST_G;
						end
					end
				end
				ST_CN: state_q <= ST_RS;
				ST_RS: state_q <= ST_RM;
				ST_RM: state_q <= ST_WL;
				ST_WL: begin
					raw_q   <= raw_now;
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (raw_q > RAW_MIN && wgt > bg_q[0]) begin
						bg_q[0] <= wgt;
						bh_q[0] <= hgt_new;
						bm_q[0] <= mag_q;
					end
					state_q <= ST_WU;
				end
				ST_WU: begin
					if (raw_q > RAW_MIN && wgt > bg_q[1]) begin
						bg_q[1] <= wgt;
						bh_q[1] <= hgt_new;
						bm_q[1] <= mag_q;
					end
					state_q <= last_q ? ST_G : ST_IDLE;
				end
				ST_G: state_q <= ST_GU;
				ST_GU: begin
					sg_q[src_q] <= g_new[15:0];
					state_q     <= is_side ? ST_HU : ST_EMIT;
				end
				ST_HU: begin
					sh_q[side] <= h_new[16:0];
					state_q    <= (sg_cur >= GATE_MIN) ? ST_P1 : ST_EMIT;
				end
				ST_P1: state_q <= ST_P2;
				ST_P2: begin
					pv_q    <= 1'b1;
					state_q <= ST_P3;
				end
				ST_P3: begin
					sp_q[side] <= p_new[15:0];
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						oidx_q      <= src_ext[1:0];
						ogain_q     <= sg_cur;
						ohgt_q      <= is_side ? sh_cur : 17'sd0;
						opitch_q    <= is_side ? sp_cur : PITCH_UNITY;
						opv_q       <= pv_q;
						olast_q     <= src_last;
						pv_q        <= 1'b0;
						if (src_last) begin
							// frame done: best gain and magnitude clear, best height restarts from smoothed height
							for (int i = 0; i < 2; i++) begin
								bg_q[i] <= '0;
								bm_q[i] <= '0;
								bh_q[i] <= sh_q[i];
							end
							state_q <= ST_IDLE;
						end else begin
							src_q   <= src_q + SIDX_W'(1);
							state_q <= ST_G;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign source_index  = oidx_q;
	assign source_gain   = ogain_q;
	assign source_height = ohgt_q;
	assign source_pitch  = opitch_q;
	assign pitch_valid   = opv_q;
	assign result_last   = olast_q;

	// inactive frame-end obstacle goes straight to frame-end smoothing
	a_skip_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !obstacle_active && frame_last) |=> !in_ready)
		else $error("frame end not started after inactive last obstacle");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_last) |-> (source_index == 2'(NUM_SOURCES - 1)))
		else $error("result_last on wrong source");

	a_pitch_side: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pitch_valid) |-> (source_index == 2'd0 || source_index == 2'd1))
		else $error("pitch update on muted source");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (source_gain <= GAIN_FULL))
		else $error("smoothed gain above full scale");

endmodule
